/* rtl/iotr_pkg.sv */
// Shared types, constants and helper functions for the ISO-TP reassembler.
package iotr_pkg;

   localparam int MaxPayloadDefault = 4095;
   localparam int SlotCount = 17;
   localparam int SlotBits = 5;
   localparam int OffsetBits = 12;
   localparam int AddrBits = SlotBits + OffsetBits;
   localparam int StoreDepth = 1 << AddrBits;

   // Input command codes.
   typedef enum logic [1:0] {
      CMD_FRAME     = 2'd0,
      CMD_READ      = 2'd1,
      CMD_RESET_ONE = 2'd2,
      CMD_RESET_ALL = 2'd3
   } cmd_type;

   // Frame types carried in the upper nibble of the first data byte.
   localparam logic [3:0] PciSingle = 4'h0;
   localparam logic [3:0] PciFirst = 4'h1;
   localparam logic [3:0] PciConsec = 4'h2;

   localparam logic [28:0] IdFunctional = 29'h7DF;
   localparam logic [28:0] IdPhysLow = 29'h7E0;
   localparam logic [28:0] IdPhysHigh = 29'h7EF;
   localparam logic [SlotBits-1:0] FunctionalSlot = 5'd16;

   localparam logic RkComplete = 1'b0;
   localparam logic RkRead = 1'b1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [28:0] can_id;
      logic [3:0]  frame_length;
      logic [63:0] frame_data;
      logic [63:0] frame_time;
      logic [11:0] read_offset;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [10:0] message_id;
      logic [63:0] message_time;
      logic [11:0] message_length;
      logic [7:0]  read_byte;
      logic        read_ok;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                  load;       // capture the accepted item
      logic                  decode;     // register the slot state of the item
      logic                  update;     // write back the slot state
      logic                  wr_en;      // write one payload byte
      logic [2:0]            wr_index;   // byte within the current frame
      logic                  rd_en;      // issue a payload read
      logic                  make_rsp;   // form the result item
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       is_obd;
      logic [3:0] wr_count;    // payload bytes to write for this item
      logic       has_rsp;     // the item gives a result
   } dp_status_type;

   // Slot number of an OBD identifier.
   function automatic logic [SlotBits-1:0] slot_of(input logic [28:0] id);
      logic [SlotBits-1:0] s;
      s = (id == IdFunctional) ? FunctionalSlot : {1'b0, id[3:0]};
      return s;
   endfunction

   function automatic logic is_obd_id(input logic [28:0] id);
      return (id == IdFunctional) || (id >= IdPhysLow && id <= IdPhysHigh);
   endfunction

endpackage

/* rtl/iotr_if.sv */
// Valid/ready channel interface carrying one payload item.
interface iotr_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/iotr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module iotr_ram #(
   parameter int Width = 8,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/iotr_datapath.sv */
// Datapath: slot state registers, frame decoding and the payload store.
module iotr_datapath
   import iotr_pkg::*;
#(
   parameter int MaxPayload = MaxPayloadDefault
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_in,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output rsp_type       rsp_out
);
   // Per-slot state.
   logic                  active_ff [SlotCount];
   logic [11:0]           explen_ff [SlotCount];
   logic [3:0]            nseq_ff [SlotCount];
   logic [11:0]           fill_ff [SlotCount];
   logic [63:0]           stime_ff [SlotCount];
   logic [11:0]           rlen_ff [SlotCount];

   // Captured item and decode results.
   req_type               item_ff;
   logic                  obd_ff;
   logic [SlotBits-1:0]   slot_ff;
   logic [3:0]            type_ff;
   logic [3:0]            dlc_ff;
   logic                  s_active_ff;
   logic [11:0]           s_explen_ff;
   logic [3:0]            s_nseq_ff;
   logic [11:0]           s_fill_ff;
   logic [63:0]           s_stime_ff;
   logic [11:0]           s_rlen_ff;

   logic [7:0]            pci;
   logic [11:0]           total;
   logic [11:0]           remaining;
   logic [3:0]            take;
   logic                  sf_ok, ff_ok, cf_ok, cf_bad, cf_done;
   logic [11:0]           fill_next;
   logic                  rd_in_range;
   logic [7:0]            rd_data;
   logic [AddrBits-1:0]   wr_addr;
   logic [AddrBits-1:0]   rd_addr;
   logic [7:0]            wr_data;
   logic [3:0]            src_byte;
   logic [11:0]           wr_off;
   logic                  rd_ok_ff;
   rsp_type               rsp_ff;

   // Capture the item and clamp the frame length.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_in;
         obd_ff  <= is_obd_id(req_in.can_id);
         slot_ff <= slot_of(req_in.can_id);
         type_ff <= req_in.frame_data[7:4];
         dlc_ff  <= (req_in.frame_length > 4'd8) ? 4'd8 : req_in.frame_length;
      end
   end

   // Read the state of the addressed slot.
   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         s_active_ff <= active_ff[slot_ff];
         s_explen_ff <= explen_ff[slot_ff];
         s_nseq_ff   <= nseq_ff[slot_ff];
         s_fill_ff   <= fill_ff[slot_ff];
         s_stime_ff  <= stime_ff[slot_ff];
         s_rlen_ff   <= rlen_ff[slot_ff];
      end
   end

   // Frame checks on the registered slot state.
   assign pci       = item_ff.frame_data[7:0];
   assign total     = {pci[3:0], item_ff.frame_data[15:8]};
   assign remaining = (s_explen_ff > s_fill_ff) ? s_explen_ff - s_fill_ff : 12'd0;
   assign take      = ({8'd0, dlc_ff - 4'd1} > remaining) ? remaining[3:0] : dlc_ff - 4'd1;
   assign fill_next = s_fill_ff + {8'd0, take};
   assign sf_ok = (type_ff == PciSingle) && (pci[3:0] != 4'd0) && (pci[3:0] <= dlc_ff - 4'd1);
   assign ff_ok = (type_ff == PciFirst) && (dlc_ff == 4'd8) && (total >= 12'd8)
                  && ({20'd0, total} <= MaxPayload[31:0]);
   assign cf_ok  = (type_ff == PciConsec) && s_active_ff && (pci[3:0] == s_nseq_ff);
   assign cf_bad = (type_ff == PciConsec) && s_active_ff && (pci[3:0] != s_nseq_ff);
   assign cf_done = cf_ok && (fill_next >= s_explen_ff);
   assign rd_in_range = (s_rlen_ff != 12'd0) && (item_ff.read_offset < s_rlen_ff);

   // Status for the controller.
   always_comb begin
      status.is_obd   = obd_ff;
      status.wr_count = 4'd0;
      status.has_rsp  = 1'b0;
      case (cmd_type'(item_ff.cmd))
         CMD_FRAME: begin
            if (obd_ff && dlc_ff != 4'd0) begin
               if (sf_ok) begin
                  status.wr_count = pci[3:0];
                  status.has_rsp  = 1'b1;
               end else if (ff_ok) begin
                  status.wr_count = 4'd6;
               end else if (cf_ok) begin
                  status.wr_count = take;
                  status.has_rsp  = cf_done;
               end
            end
         end
         CMD_READ: status.has_rsp = 1'b1;
         default: status.has_rsp = 1'b0;
      endcase
   end

   // Write back the slot state; reset all clears every slot at write-back.
   always_ff @(posedge clock) begin
      if (reset || (cmd.update && item_ff.cmd == CMD_RESET_ALL)) begin
         for (int i = 0; i < SlotCount; i++) begin
            active_ff[i] <= 1'b0;
            explen_ff[i] <= '0;
            nseq_ff[i]   <= '0;
            fill_ff[i]   <= '0;
            stime_ff[i]  <= '0;
            rlen_ff[i]   <= '0;
         end
      end else if (cmd.update && obd_ff) begin
         if (item_ff.cmd == CMD_RESET_ONE) begin
            active_ff[slot_ff] <= 1'b0;
            explen_ff[slot_ff] <= '0;
            nseq_ff[slot_ff]   <= '0;
            fill_ff[slot_ff]   <= '0;
            stime_ff[slot_ff]  <= '0;
            rlen_ff[slot_ff]   <= '0;
         end else if (item_ff.cmd == CMD_FRAME && dlc_ff != 4'd0) begin
            if (sf_ok) begin
               active_ff[slot_ff] <= 1'b0;
               fill_ff[slot_ff]   <= '0;
               stime_ff[slot_ff]  <= item_ff.frame_time;
               rlen_ff[slot_ff]   <= {8'd0, pci[3:0]};
            end else if (ff_ok) begin
               explen_ff[slot_ff] <= total;
               fill_ff[slot_ff]   <= 12'd6;
               nseq_ff[slot_ff]   <= 4'd1;
               stime_ff[slot_ff]  <= item_ff.frame_time;
               rlen_ff[slot_ff]   <= '0;
               active_ff[slot_ff] <= 1'b1;
            end else if (cf_bad) begin
               active_ff[slot_ff] <= 1'b0;
            end else if (cf_ok) begin
               nseq_ff[slot_ff] <= s_nseq_ff + 4'd1;
               fill_ff[slot_ff] <= fill_next;
               if (cf_done) begin
                  active_ff[slot_ff] <= 1'b0;
                  rlen_ff[slot_ff]   <= s_explen_ff;
               end
            end
         end
      end
   end

   // Payload byte selection for one write per cycle.
   always_comb begin
      src_byte = 4'd0;
      wr_off   = '0;
      if (type_ff == PciFirst) begin
         src_byte = {1'b0, cmd.wr_index} + 4'd2;
         wr_off   = {9'd0, cmd.wr_index};
      end else if (type_ff == PciConsec) begin
         src_byte = {1'b0, cmd.wr_index} + 4'd1;
         wr_off   = s_fill_ff + {9'd0, cmd.wr_index};
      end else begin
         src_byte = {1'b0, cmd.wr_index} + 4'd1;
         wr_off   = {9'd0, cmd.wr_index};
      end
   end

   assign wr_data = item_ff.frame_data[{src_byte[2:0], 3'b000} +: 8];
   assign wr_addr = {slot_ff, wr_off};
   assign rd_addr = {slot_ff, item_ff.read_offset};

   iotr_ram #(.Width(8), .Depth(StoreDepth)) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_ok_ff <= rd_in_range;
      end
   end

   // Form the result item.
   always_ff @(posedge clock) begin
      if (cmd.make_rsp) begin
         rsp_ff.message_id <= item_ff.can_id[10:0];
         if (item_ff.cmd == CMD_READ) begin
            rsp_ff.result_kind    <= RkRead;
            rsp_ff.message_time   <= obd_ff ? s_stime_ff : 64'd0;
            rsp_ff.message_length <= obd_ff ? s_rlen_ff : 12'd0;
            rsp_ff.read_ok        <= obd_ff && rd_ok_ff;
            rsp_ff.read_byte      <= (obd_ff && rd_ok_ff) ? rd_data : 8'd0;
         end else begin
            rsp_ff.result_kind    <= RkComplete;
            rsp_ff.message_time   <= sf_ok ? item_ff.frame_time : s_stime_ff;
            rsp_ff.message_length <= sf_ok ? {8'd0, pci[3:0]} : s_explen_ff;
            rsp_ff.read_ok        <= 1'b0;
            rsp_ff.read_byte      <= 8'd0;
         end
      end
   end

   assign rsp_out = rsp_ff;
endmodule

/* rtl/iotr_ctrl.sv */
// Controller: sequences decode, byte writes, reads and result delivery.
module iotr_ctrl
   import iotr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   iotr_if.sink          req,
   iotr_if.source        rsp,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_DECODE, ST_CHECK, ST_WRITE, ST_READ, ST_FORM, ST_SEND
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] idx_ff, idx_in;
   logic       has_rsp_ff, has_rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign rsp.valid = rsp_valid_ff;

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      has_rsp_in   = has_rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.wr_index = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = accept;
            if (accept) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_CHECK: begin
            has_rsp_in = status.has_rsp;
            idx_in     = 3'd0;
            if (status.wr_count != 4'd0) begin
               state_in = ST_WRITE;
            end else if (status.has_rsp) begin
               cmd.rd_en = 1'b1;
               state_in  = ST_READ;
            end else begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_WRITE: begin
            cmd.wr_en = 1'b1;
            idx_in    = idx_ff + 3'd1;
            if ({1'b0, idx_ff} + 4'd1 >= status.wr_count) begin
               if (has_rsp_ff) begin
                  state_in = ST_FORM;
               end else begin
                  cmd.update = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         ST_READ: begin
            state_in = ST_FORM;
         end
         ST_FORM: begin
            cmd.make_rsp = 1'b1;
            cmd.update   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_SEND;
         end
         ST_SEND: begin
            if (rsp.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         has_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         has_rsp_ff   <= has_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

/* rtl/isotp_obd_reassembler_unit.sv */
// Top level of the ISO-TP OBD receive reassembler.
// One item at a time: an item is loaded, decoded and checked, then its payload
// bytes are written one per cycle into the byte-wide payload store (up to seven
// for a frame); a read then reads the store, and a result is registered and
// held until rsp_ready. The payload store has one write and one registered read
// port, which sets the per-byte pace. Reset all (cmd 3) clears the 17 session
// slots at once; the store needs no clearing.
module isotp_obd_reassembler_unit
   import iotr_pkg::*;
#(
   parameter int MaxPayload = MaxPayloadDefault
) (
   input  logic   clock,
   input  logic   reset,
   iotr_if.sink   req,
   iotr_if.source rsp
);
   dp_cmd_type    cmd;
   dp_status_type status;
   rsp_type       rsp_payload;

   iotr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .rsp    (rsp),
      .status (status),
      .cmd    (cmd)
   );

   iotr_datapath #(.MaxPayload(MaxPayload)) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req.payload),
      .cmd     (cmd),
      .status  (status),
      .rsp_out (rsp_payload)
   );

   assign rsp.payload = rsp_payload;
endmodule

/* rtl/iotr_checker.sv */
// Port-level assertions for the reassembler, bound to the top level.
module iotr_checker
   import iotr_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_read_ok,
   input logic rsp_kind
);
   // An item is not taken while a result waits.
   a_no_accept_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken while result pending");

   // A result stays offered until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");

   // Completion results never flag a read.
   a_complete_no_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == RkComplete |-> !rsp_read_ok)
      else $error("completion with read_ok");

   // After an accept the block is busy on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready after accept");
endmodule

bind isotp_obd_reassembler_unit iotr_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_read_ok (rsp.payload.read_ok),
   .rsp_kind    (rsp.payload.result_kind)
);
